FILE: sv/srb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants for the shape record builder: command and
// result beat layouts, action and result codes, store geometry.
// ----------------------------------------------------------------------------
package srb_pkg;

    // Store and id geometry
    localparam int MAX_IDS       = 256;
    localparam int FRACTION_BITS = 8;
    localparam int TRAILER_BYTES = 16;
    localparam int IDX_W         = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int ENTRY_W       = 33;   // valid flag + trailer offset
    localparam int CFG_INDEX_W   = 2;

    localparam logic [15:0] CIRCLE_ITEMS = 16'd3;
    localparam logic [31:0] BREAK_WORD   = 32'h0000_8000;

    // Action codes
    localparam logic [2:0] ACT_OPEN   = 3'd0;
    localparam logic [2:0] ACT_CLOSE  = 3'd1;
    localparam logic [2:0] ACT_CIRCLE = 3'd2;
    localparam logic [2:0] ACT_BEGIN  = 3'd3;
    localparam logic [2:0] ACT_VERTEX = 3'd4;
    localparam logic [2:0] ACT_END    = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_TRAILER = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;
    localparam logic [1:0] KIND_ACCEPT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COORD_LIMIT  = 2'd1;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         record_id;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic signed [31:0] radius;
        logic               new_contour;
    } srb_cmd_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [31:0]        write_offset;
        logic [31:0]        data_word;
        logic [7:0]         out_record_id;
        logic               out_shape_kind;
        logic [15:0]        out_item_count;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic [8:0]         distinct_ids;
        logic               last;
    } srb_rec_t;

endpackage : srb_pkg
`default_nettype wire

FILE: sv/shape_record_builder_unit.sv
`default_nettype none
// A result-only command answers in the cycle after it is taken; a circle emits three
// data beats, then the trailer, its index read overlapped with the radius beat; a
// vertex emits its pair, after a break marker on a new contour; an end polygon reads
// the index, then emits the trailer. Commands are taken one at a time, set by the
// read-modify-write of the id index RAM (registered read). After reset and after every
// open session the index RAM is swept clear with no command taken; configuration writes are always taken.
// ----------------------------------------------------------------------------
// shape_record_builder_unit
// Builds circle and polygon records in a linear store, tracks bounding boxes
// and enters every trailer offset in an id-indexed table kept in RAM.
// ----------------------------------------------------------------------------
module shape_record_builder_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire srb_pkg::srb_cmd_t               cmd,
    output logic                                 rec_valid,
    input  wire logic                            rec_ready,
    output srb_pkg::srb_rec_t                    rec,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [srb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                     cfg_data
);

    import srb_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WORD  = 4'b0100,
        ST_LOOK  = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0]         CLR_LAST  = IDX_W'(MAX_IDS - 1);
    localparam logic signed [33:0]       ROUND_ADD = 34'((1 << FRACTION_BITS) - 1);
    localparam logic [31:0]              TRL_BYTES = 32'(TRAILER_BYTES);

    // Saturating item counter step
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Fixed point to whole pixels (floor), clamped to 16 bits
    function automatic logic signed [15:0] to_pixel(input logic signed [33:0] v);
        logic signed [33:0] s;
        s = v >>> FRACTION_BITS;
        if (s > 34'sd32767)
            return 16'sh7FFF;
        else if (s < -34'sd32768)
            return 16'sh8000;
        else
            return s[15:0];
    endfunction

    state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    srb_rec_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] first_offset_reg, first_offset_next;
    logic [14:0] coord_limit_reg, coord_limit_next;
    logic [31:0] wp_reg, wp_next;
    logic [8:0] count_reg, count_next;
    logic session_reg, session_next;
    logic poly_active_reg, poly_active_next;
    logic box_seen_reg, box_seen_next;
    logic [7:0] poly_id_reg, poly_id_next;
    logic [15:0] poly_count_reg, poly_count_next;
    logic signed [15:0] box_reg [4];
    logic signed [15:0] box_next [4];
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] rad_reg, rad_next;
    logic [31:0] word_reg, word_next;
    logic circle_reg, circle_next;
    logic step_reg, step_next;
    logic [7:0] tid_reg, tid_next;
    logic [31:0] toff_reg, toff_next;
    logic [15:0] tcount_reg, tcount_next;
    logic signed [33:0] tb_reg [4];
    logic signed [33:0] tb_next [4];

    logic out_free;
    logic ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [23:0] cmd_id_ext, tid_ext, pid_ext;
    logic shape_ok;
    logic signed [31:0] lim_pos, lim_neg, cx, cy;
    logic [31:0] vword;
    logic [15:0] cnt1;
    logic [8:0] new_count;
    logic signed [33:0] xe, ye, re_ext;

    // Index table: valid flag and trailer offset per id
    srb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_IDS)
    ) u_index (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || rec_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;

    // Id widening and shape admission
    assign cmd_id_ext = 24'(cmd.record_id);
    assign tid_ext    = 24'(tid_reg);
    assign pid_ext    = 24'(poly_id_reg);
    assign shape_ok   = session_reg && !poly_active_reg && (cmd_id_ext < 24'(MAX_IDS));

    // Vertex clamp and pair packing
    assign lim_pos = 32'(coord_limit_reg);
    assign lim_neg = -lim_pos;
    assign cx = (cmd.x_value > lim_pos) ? lim_pos :
                ((cmd.x_value < lim_neg) ? lim_neg : cmd.x_value);
    assign cy = (cmd.y_value > lim_pos) ? lim_pos :
                ((cmd.y_value < lim_neg) ? lim_neg : cmd.y_value);
    assign vword = {cy[15:0], cx[15:0]};
    assign cnt1  = sat_inc(poly_count_reg);

    // Circle box operands
    assign xe     = 34'(x_reg);
    assign ye     = 34'(y_reg);
    assign re_ext = {2'b00, rad_reg};

    assign new_count = count_reg + (ram_rdata[ENTRY_W-1] ? 9'd0 : 9'd1);

    // Next-state logic
    always_comb
    begin
        srb_rec_t res;
        logic load;

        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        first_offset_next = first_offset_reg;
        coord_limit_next  = coord_limit_reg;
        wp_next           = wp_reg;
        count_next        = count_reg;
        session_next      = session_reg;
        poly_active_next  = poly_active_reg;
        box_seen_next     = box_seen_reg;
        poly_id_next      = poly_id_reg;
        poly_count_next   = poly_count_reg;
        box_next          = box_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        rad_next          = rad_reg;
        word_next         = word_reg;
        circle_next       = circle_reg;
        step_next         = step_reg;
        tid_next          = tid_reg;
        toff_next         = toff_reg;
        tcount_next       = tcount_reg;
        tb_next           = tb_reg;
        ram_we            = 1'b0;
        ram_waddr         = tid_ext[IDX_W-1:0];
        ram_wdata         = {1'b1, toff_reg};
        ram_re            = 1'b0;
        ram_raddr         = tid_ext[IDX_W-1:0];
        res               = '0;
        load              = 1'b0;

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_OFFSET: first_offset_next = cfg_data;
                CFG_COORD_LIMIT:  coord_limit_next  = cfg_data[14:0];
                default:          ;
            endcase
        end

        case (state_reg)
            // Sweep the index RAM, one entry a cycle
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            // Take a command and emit its first beat (an end polygon starts the index read)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    load             = 1'b1;
                    res.last         = 1'b1;
                    res.distinct_ids = count_reg;
                    res.result_kind  = KIND_REJECT;
                    case (cmd.action)
                        ACT_OPEN:
                        begin
                            res.result_kind  = KIND_ACCEPT;
                            res.distinct_ids = '0;
                            count_next       = '0;
                            wp_next          = first_offset_reg;
                            session_next     = 1'b1;
                            poly_active_next = 1'b0;
                            box_seen_next    = 1'b0;
                            poly_count_next  = '0;
                            box_next         = '{default: '0};
                            clr_cnt_next     = '0;
                            state_next       = ST_CLEAR;
                        end
                        ACT_CLOSE:
                        begin
                            res.result_kind  = KIND_ACCEPT;
                            session_next     = 1'b0;
                            poly_active_next = 1'b0;
                            box_seen_next    = 1'b0;
                            poly_count_next  = '0;
                            box_next         = '{default: '0};
                        end
                        ACT_CIRCLE:
                        begin
                            if (shape_ok)
                            begin
                                res.result_kind  = KIND_DATA;
                                res.last         = 1'b0;
                                res.write_offset = wp_reg;
                                res.data_word    = cmd.x_value;
                                wp_next          = wp_reg + 32'd4;
                                x_next           = cmd.x_value;
                                y_next           = cmd.y_value;
                                if (cmd.radius == 32'sh8000_0000)
                                    rad_next = 32'h7FFF_FFFF;
                                else if (cmd.radius < 0)
                                    rad_next = -cmd.radius;
                                else
                                    rad_next = cmd.radius;
                                tid_next    = cmd.record_id;
                                circle_next = 1'b1;
                                step_next   = 1'b0;
                                state_next  = ST_WORD;
                            end
                        end
                        ACT_BEGIN:
                        begin
                            if (shape_ok)
                            begin
                                res.result_kind  = KIND_ACCEPT;
                                poly_active_next = 1'b1;
                                poly_id_next     = cmd.record_id;
                                box_seen_next    = 1'b0;
                                poly_count_next  = '0;
                                box_next         = '{default: '0};
                            end
                        end
                        ACT_VERTEX:
                        begin
                            if (poly_active_reg)
                            begin
                                // Fold the clamped vertex into the box
                                box_seen_next = 1'b1;
                                if (!box_seen_reg)
                                begin
                                    box_next[0] = cx[15:0];
                                    box_next[2] = cx[15:0];
                                    box_next[1] = cy[15:0];
                                    box_next[3] = cy[15:0];
                                end
                                else
                                begin
                                    if ($signed(cx[15:0]) < box_reg[0]) box_next[0] = cx[15:0];
                                    if ($signed(cx[15:0]) > box_reg[2]) box_next[2] = cx[15:0];
                                    if ($signed(cy[15:0]) < box_reg[1]) box_next[1] = cy[15:0];
                                    if ($signed(cy[15:0]) > box_reg[3]) box_next[3] = cy[15:0];
                                end
                                res.result_kind  = KIND_DATA;
                                res.write_offset = wp_reg;
                                wp_next          = wp_reg + 32'd4;
                                if (cmd.new_contour || (poly_count_reg == 16'd0))
                                begin
                                    // Break marker first, vertex pair follows
                                    res.data_word   = BREAK_WORD;
                                    res.last        = 1'b0;
                                    word_next       = vword;
                                    circle_next     = 1'b0;
                                    poly_count_next = sat_inc(cnt1);
                                    state_next      = ST_WORD;
                                end
                                else
                                begin
                                    res.data_word   = vword;
                                    poly_count_next = cnt1;
                                end
                            end
                        end
                        ACT_END:
                        begin
                            if (poly_active_reg)
                            begin
                                // Look up the id, trailer goes out next
                                load             = 1'b0;
                                toff_next        = wp_reg;
                                wp_next          = wp_reg + TRL_BYTES;
                                tid_next         = poly_id_reg;
                                tcount_next      = poly_count_reg;
                                circle_next      = 1'b0;
                                tb_next[0]       = 34'(box_reg[0]);
                                tb_next[1]       = 34'(box_reg[1]);
                                tb_next[2]       = 34'(box_reg[2]) + ROUND_ADD;
                                tb_next[3]       = 34'(box_reg[3]) + ROUND_ADD;
                                ram_re           = 1'b1;
                                ram_raddr        = pid_ext[IDX_W-1:0];
                                poly_active_next = 1'b0;
                                box_seen_next    = 1'b0;
                                poly_count_next  = '0;
                                box_next         = '{default: '0};
                                state_next       = ST_LOOK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Emit the remaining data beats of a circle or vertex
            ST_WORD:
            begin
                if (circle_reg)
                begin
                    tb_next[0] = xe - re_ext;
                    tb_next[1] = ye - re_ext;
                    tb_next[2] = xe + re_ext + ROUND_ADD;
                    tb_next[3] = ye + re_ext + ROUND_ADD;
                end
                if (out_free)
                begin
                    load             = 1'b1;
                    res.result_kind  = KIND_DATA;
                    res.write_offset = wp_reg;
                    res.distinct_ids = count_reg;
                    wp_next          = wp_reg + 32'd4;
                    if (!circle_reg)
                    begin
                        res.data_word = word_reg;
                        res.last      = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (!step_reg)
                    begin
                        res.data_word = y_reg;
                        step_next     = 1'b1;
                    end
                    else
                    begin
                        res.data_word = rad_reg;
                        toff_next     = wp_reg + 32'd4;
                        wp_next       = wp_reg + 32'd4 + TRL_BYTES;
                        tcount_next   = CIRCLE_ITEMS;
                        ram_re        = 1'b1;
                        ram_raddr     = tid_ext[IDX_W-1:0];
                        state_next    = ST_LOOK;
                    end
                end
            end

            // Emit the trailer and write the index entry back
            ST_LOOK:
            begin
                if (out_free)
                begin
                    load               = 1'b1;
                    res.result_kind    = KIND_TRAILER;
                    res.write_offset   = toff_reg;
                    res.out_record_id  = tid_reg;
                    res.out_shape_kind = circle_reg;
                    res.out_item_count = tcount_reg;
                    res.box_left       = to_pixel(tb_reg[0]);
                    res.box_top        = to_pixel(tb_reg[1]);
                    res.box_right      = to_pixel(tb_reg[2]);
                    res.box_bottom     = to_pixel(tb_reg[3]);
                    res.distinct_ids   = new_count;
                    res.last           = 1'b1;
                    count_next         = new_count;
                    ram_we             = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: load or drain
        if (load)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (rec_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            first_offset_reg <= '0;
            coord_limit_reg  <= 15'h7FFF;
            wp_reg           <= '0;
            count_reg        <= '0;
            session_reg      <= 1'b0;
            poly_active_reg  <= 1'b0;
            box_seen_reg     <= 1'b0;
            poly_id_reg      <= '0;
            poly_count_reg   <= '0;
            box_reg          <= '{default: '0};
            circle_reg       <= 1'b0;
            step_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            out_valid_reg    <= out_valid_next;
            first_offset_reg <= first_offset_next;
            coord_limit_reg  <= coord_limit_next;
            wp_reg           <= wp_next;
            count_reg        <= count_next;
            session_reg      <= session_next;
            poly_active_reg  <= poly_active_next;
            box_seen_reg     <= box_seen_next;
            poly_id_reg      <= poly_id_next;
            poly_count_reg   <= poly_count_next;
            box_reg          <= box_next;
            circle_reg       <= circle_next;
            step_reg         <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rad_reg    <= rad_next;
        word_reg   <= word_next;
        tid_reg    <= tid_next;
        toff_reg   <= toff_next;
        tcount_reg <= tcount_next;
        tb_reg     <= tb_next;
    end

    // Checks
    a_clear_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd_ready)
        else $error("command taken during index sweep");

    a_poly_needs_session: assert property (@(posedge clk) disable iff (!rst_n)
        poly_active_reg |-> session_reg)
        else $error("polygon active outside a session");

    a_no_ram_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("index read and write in the same cycle");

    a_lookup_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_LOOK) && (state_next == ST_LOOK)) |-> ram_re)
        else $error("trailer state entered without an index read");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOOK) && out_free) |=> (count_reg >= $past(count_reg)))
        else $error("distinct id count fell on a trailer");

endmodule : shape_record_builder_unit
`default_nettype wire

FILE: sv/srb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : srb_ram
`default_nettype wire
